>>> sv/tlrd_pkg.sv
package tlrd_pkg;

	localparam int TILE_SIDE_DEF = 128;
	localparam int START_W = 14;

	localparam logic [1:0] MODE_RAW    = 2'd0;
	localparam logic [1:0] MODE_NIBBLE = 2'd1;
	localparam logic [1:0] MODE_BYTE   = 2'd2;

	localparam logic [1:0] PH_EMPTY = 2'd0;
	localparam logic [1:0] PH_HELD  = 2'd1;
	localparam logic [1:0] PH_HALF  = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_EARLY = 2'd1;
	localparam logic [1:0] ERR_OVF   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       tile_start;
		logic       data_end;
	} item_t;

	typedef struct packed {
		logic [7:0]         run_value;
		logic [7:0]         run_length;
		logic [START_W-1:0] run_start;
		logic               tile_done;
		logic [1:0]         error_code;
	} result_t;

endpackage

>>> sv/tlrd_in_reg.sv
module tlrd_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tlrd_pkg::item_t in_item,
	output logic            item_valid,
	input  logic            item_take,
	output tlrd_pkg::item_t item
);

	logic            valid_s1;
	tlrd_pkg::item_t item_s1;

	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (item_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> sv/tlrd_core.sv
module tlrd_core #(
	parameter int TILE_SIDE = tlrd_pkg::TILE_SIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        mode,
	input  logic              item_valid,
	output logic              item_take,
	input  tlrd_pkg::item_t   item,
	output logic              out_valid,
	input  logic              out_ready,
	output tlrd_pkg::result_t result
);

	localparam int TILE_PIXELS = TILE_SIDE * TILE_SIDE;
	localparam int POS_W = $clog2(TILE_PIXELS + 1);
	localparam int COL_W = $clog2(TILE_SIDE);
	localparam int SUM_W = $clog2(TILE_SIDE + 256);
	localparam int RECIP_SH = 22;
	localparam int RECIP = ((1 << RECIP_SH) + TILE_SIDE - 1) / TILE_SIDE;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam logic [POS_W:0]     PIXELS_C = (POS_W + 1)'(TILE_PIXELS);
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam logic [SUM_W-1:0]   TILE_C = SUM_W'(TILE_SIDE);

	logic [POS_W-1:0] pos_q, pos_c, nxt_pos;
	logic [COL_W-1:0] col_q, col_c, nxt_col;
	logic [1:0]       phase_q, phase_c, nxt_phase;
	logic [7:0]       held_q, held_c, nxt_held;
	logic             active_q, active_c, nxt_active;
	logic             out_valid_q;
	tlrd_pkg::result_t result_q;

	logic             have, done, emit;
	logic [7:0]       len, val;
	logic [1:0]       err;
	logic [POS_W:0]   pos_sum;
	logic [SUM_W-1:0] col_sum, quot, rem, quot_mul;
	logic [PROD_W-1:0] prod;

	assign item_take = item_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// column = position mod tile side, kept alongside the position
	assign col_sum  = SUM_W'(col_c) + SUM_W'(len);
	assign prod     = PROD_W'(col_sum) * PROD_W'(RECIP_C);
	assign quot     = SUM_W'(prod >> RECIP_SH);
	assign quot_mul = quot * TILE_C;
	assign rem      = col_sum - quot_mul;
	assign pos_sum  = (POS_W + 1)'(pos_c) + (POS_W + 1)'(len);

	always_comb begin
		pos_c    = item.tile_start ? '0 : pos_q;
		col_c    = item.tile_start ? '0 : col_q;
		phase_c  = item.tile_start ? tlrd_pkg::PH_EMPTY : phase_q;
		held_c   = item.tile_start ? '0 : held_q;
		active_c = item.tile_start || active_q;

		have      = 1'b0;
		done      = 1'b0;
		len       = '0;
		val       = '0;
		err       = tlrd_pkg::ERR_NONE;
		nxt_phase = phase_c;
		nxt_held  = held_c;

		case (mode)
			tlrd_pkg::MODE_NIBBLE: begin
				if (phase_c == tlrd_pkg::PH_HELD) begin
					len       = {4'd0, held_c[7:4]};
					val       = {held_c[3:0], item.data_byte[7:4]};
					nxt_held  = item.data_byte;
					nxt_phase = tlrd_pkg::PH_HALF;
					have      = 1'b1;
				end else if (phase_c == tlrd_pkg::PH_HALF) begin
					if (col_c == '0) begin
						nxt_held  = item.data_byte;
						nxt_phase = tlrd_pkg::PH_HELD;
					end else begin
						len       = {4'd0, held_c[3:0]};
						val       = item.data_byte;
						nxt_phase = tlrd_pkg::PH_EMPTY;
						have      = 1'b1;
					end
				end else begin
					nxt_held  = item.data_byte;
					nxt_phase = tlrd_pkg::PH_HELD;
				end
			end
			tlrd_pkg::MODE_BYTE: begin
				if (phase_c != tlrd_pkg::PH_EMPTY) begin
					len       = held_c;
					val       = item.data_byte;
					nxt_phase = tlrd_pkg::PH_EMPTY;
					have      = 1'b1;
				end else begin
					nxt_held  = item.data_byte;
					nxt_phase = tlrd_pkg::PH_HELD;
				end
			end
			default: begin
				len  = 8'd1;
				val  = item.data_byte;
				have = 1'b1;
			end
		endcase

		nxt_pos = pos_c;
		nxt_col = col_c;
		if (have) begin
			if (pos_sum > PIXELS_C) begin
				err  = tlrd_pkg::ERR_OVF;
				done = 1'b1;
			end else begin
				nxt_pos = pos_sum[POS_W-1:0];
				nxt_col = rem[COL_W-1:0];
				done    = (pos_sum == PIXELS_C);
			end
		end
		if (!done && item.data_end) begin
			err  = tlrd_pkg::ERR_EARLY;
			done = 1'b1;
		end

		emit       = active_c && (have || done);
		nxt_active = active_c && !done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			col_q    <= '0;
			phase_q  <= tlrd_pkg::PH_EMPTY;
			held_q   <= '0;
			active_q <= 1'b0;
		end else if (item_take && active_c) begin
			pos_q    <= nxt_pos;
			col_q    <= nxt_col;
			phase_q  <= nxt_phase;
			held_q   <= nxt_held;
			active_q <= nxt_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && emit) begin
			result_q.run_value  <= val;
			result_q.run_length <= len;
			result_q.run_start  <= tlrd_pkg::START_W'(pos_c);
			result_q.tile_done  <= done;
			result_q.error_code <= err;
		end
	end

endmodule

>>> sv/tile_run_length_decoder.sv
// Tile run-length decoder: one compressed byte per transfer, at most one run out.
// An input byte is registered in the input register and its run in the result
// register.
// Throughput: one byte per cycle unless out_ready stalls it, set by the single decode
// stage that updates position, phase and held byte; output stalls reach the input.
// Reset: arst_n clears mode to raw, position, phase, held byte and tile state.
module tile_run_length_decoder #(
	parameter int TILE_SIDE = tlrd_pkg::TILE_SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         tile_start,
	input  logic                         data_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   run_value,
	output logic [7:0]                   run_length,
	output logic [tlrd_pkg::START_W-1:0] run_start,
	output logic                         tile_done,
	output logic [1:0]                   error_code
);

	logic [1:0]        mode_q;
	tlrd_pkg::item_t   in_item, item;
	tlrd_pkg::result_t result;
	logic              item_valid, item_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tlrd_pkg::MODE_RAW;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign in_item.data_byte  = data_byte;
	assign in_item.tile_start = tile_start;
	assign in_item.data_end   = data_end;

	tlrd_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	tlrd_core #(
		.TILE_SIDE (TILE_SIDE)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result)
	);

	assign run_value  = result.run_value;
	assign run_length = result.run_length;
	assign run_start  = result.run_start;
	assign tile_done  = result.tile_done;
	assign error_code = result.error_code;

endmodule

>>> test/tlrd_run_checker.sv
`timescale 1ns / 100ps

module tlrd_run_checker #(
	parameter int TILE_SIDE = tlrd_pkg::TILE_SIDE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [1:0]                   cfg_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         tile_start,
	input  logic                         data_end,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [7:0]                   run_value,
	input  logic [7:0]                   run_length,
	input  logic [tlrd_pkg::START_W-1:0] run_start,
	input  logic                         tile_done,
	input  logic [1:0]                   error_code,
	output int                           mismatch_count,
	output int                           outstanding,
	output int                           runs_checked,
	output int                           tiles_full,
	output int                           tiles_early,
	output int                           tiles_ovf
);
	import tlrd_pkg::*;

	localparam int TILE_PIX = TILE_SIDE * TILE_SIDE;

	logic [1:0] cur_mode;
	int         px_pos;
	logic [1:0] phase;
	logic [7:0] held;
	bit         busy;

	result_t runs_q[$];
	result_t want, got;
	int      mism, pend, n_runs, n_full, n_early, n_ovf;

	assign mismatch_count = mism;
	assign outstanding    = pend;
	assign runs_checked   = n_runs;
	assign tiles_full     = n_full;
	assign tiles_early    = n_early;
	assign tiles_ovf      = n_ovf;

	initial begin
		mism = 0;
		n_runs = 0;
		n_full = 0;
		n_early = 0;
		n_ovf = 0;
	end

	task automatic report_mismatch(input string what);
		mism++;
		$display("mismatch at %0t ns, run %0d: %s", $time, n_runs, what);
	endtask

	// one compressed byte in, at most one run descriptor out
	function automatic bit decode_run(input logic [7:0] b, input logic st, input logic fin,
			output result_t r);
		logic [7:0] val;
		logic [7:0] len;
		logic [1:0] err;
		int         start_at;
		bit         got_run;
		bit         closes;
		val = 8'd0;
		len = 8'd0;
		err = ERR_NONE;
		got_run = 1'b0;
		closes = 1'b0;
		r = '0;
		if (st) begin
			px_pos = 0;
			phase = PH_EMPTY;
			held = 8'd0;
			busy = 1'b1;
		end
		if (!busy) begin
			return 1'b0;
		end
		start_at = px_pos;
		case (cur_mode)
			MODE_NIBBLE: begin
				if (phase == PH_HELD) begin
					len = {4'd0, held[7:4]};
					val = {held[3:0], b[7:4]};
					held = b;
					phase = PH_HALF;
					got_run = 1'b1;
				end else if (phase == PH_HALF) begin
					if (px_pos % TILE_SIDE == 0) begin
						// row start: pending half byte dropped
						held = b;
						phase = PH_HELD;
					end else begin
						len = {4'd0, held[3:0]};
						val = b;
						phase = PH_EMPTY;
						got_run = 1'b1;
					end
				end else begin
					held = b;
					phase = PH_HELD;
				end
			end
			MODE_BYTE: begin
				if (phase != PH_EMPTY) begin
					len = held;
					val = b;
					phase = PH_EMPTY;
					got_run = 1'b1;
				end else begin
					held = b;
					phase = PH_HELD;
				end
			end
			default: begin
				val = b;
				len = 8'd1;
				got_run = 1'b1;
			end
		endcase
		if (got_run) begin
			if (px_pos + int'(len) > TILE_PIX) begin
				err = ERR_OVF;
				closes = 1'b1;
			end else begin
				px_pos = px_pos + int'(len);
				if (px_pos == TILE_PIX) begin
					closes = 1'b1;
				end
			end
		end
		if (!closes && fin) begin
			err = ERR_EARLY;
			closes = 1'b1;
		end
		if (!got_run && !closes) begin
			return 1'b0;
		end
		if (closes) begin
			busy = 1'b0;
		end
		r.run_value  = val;
		r.run_length = len;
		r.run_start  = start_at[START_W-1:0];
		r.tile_done  = closes;
		r.error_code = err;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = MODE_RAW;
			px_pos = 0;
			phase = PH_EMPTY;
			held = 8'd0;
			busy = 1'b0;
			runs_q.delete();
			pend <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cur_mode = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (decode_run(data_byte, tile_start, data_end, want)) begin
					runs_q.push_back(want);
				end
			end
			if (out_valid && out_ready) begin
				got.run_value  = run_value;
				got.run_length = run_length;
				got.run_start  = run_start;
				got.tile_done  = tile_done;
				got.error_code = error_code;
				if (runs_q.size() == 0) begin
					report_mismatch("run transfer with nothing expected");
				end else begin
					want = runs_q.pop_front();
					if (got.run_value !== want.run_value)
						report_mismatch($sformatf("run_value %0h, expected %0h",
							got.run_value, want.run_value));
					if (got.run_length !== want.run_length)
						report_mismatch($sformatf("run_length %0d, expected %0d",
							got.run_length, want.run_length));
					if (got.run_start !== want.run_start)
						report_mismatch($sformatf("run_start %0d, expected %0d",
							got.run_start, want.run_start));
					if (got.tile_done !== want.tile_done)
						report_mismatch($sformatf("tile_done %0b, expected %0b",
							got.tile_done, want.tile_done));
					if (got.error_code !== want.error_code)
						report_mismatch($sformatf("error_code %0d, expected %0d",
							got.error_code, want.error_code));
					n_runs++;
					if (want.tile_done) begin
						case (want.error_code)
							ERR_NONE:  n_full++;
							ERR_EARLY: n_early++;
							default:   n_ovf++;
						endcase
					end
				end
			end
			pend <= runs_q.size();
		end
	end

endmodule

>>> test/tile_run_length_decoder_test.sv
`timescale 1ns / 100ps

module tile_run_length_decoder_test;
	import tlrd_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int TILE_PIX      = TILE_SIDE_DEF * TILE_SIDE_DEF;
	localparam int PHASE_ITEMS   = 317;
	localparam int HOLD_CYCLES   = 300;
	localparam int WATCH_LIMIT   = 2000;
	localparam int END_EXACT     = 0;
	localparam int END_OVERFLOW  = 1;
	localparam int END_OPEN      = 2;
	localparam int END_ANY       = 3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               tile_start;
	logic               data_end;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         run_value;
	logic [7:0]         run_length;
	logic [START_W-1:0] run_start;
	logic               tile_done;
	logic [1:0]         error_code;
	int                 mismatch_count;
	int                 outstanding;
	int                 runs_checked;
	int                 tiles_full;
	int                 tiles_early;
	int                 tiles_ovf;

	int send_idle_pct = 38;
	int recv_idle_pct = 46;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int bytes_sent = 0;
	int cfg_writes = 0;
	int idle_run;

	tile_run_length_decoder dut (.*);

	tlrd_run_checker checker_i (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b, input logic st, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		tile_start <= st;
		data_end   <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	// mode writes only once every run has drained
	task automatic set_mode(input logic [1:0] m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	// byte-count tile with large runs, tracked so its end can be steered
	task automatic fill_tile(input int ending);
		int px;
		int rem;
		int cnt;
		int left;
		int e;
		bit first;
		bit fin;
		bit on_count;
		bit open_end;
		px = 0;
		left = 0;
		first = 1'b1;
		open_end = 1'b0;
		set_mode(MODE_BYTE);
		while (px < TILE_PIX && !open_end) begin
			rem = TILE_PIX - px;
			if (rem > 255) begin
				cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
					: $urandom_range(160, 255);
			end else begin
				e = (ending == END_ANY) ? $urandom_range(END_EXACT, END_OPEN) : ending;
				if (e == END_EXACT) begin
					cnt = rem;
				end else if (e == END_OVERFLOW) begin
					cnt = (rem < 255) ? $urandom_range(rem + 1, 255) : 254;
				end else begin
					left = $urandom_range(1, (rem < 3) ? rem : 3);
					cnt = rem - left;
					open_end = 1'b1;
				end
			end
			fin = (ending == END_ANY) && ($urandom_range(0, 149) == 0);
			on_count = ($urandom_range(0, 1) == 1);
			send_byte(cnt[7:0], first, fin && on_count);
			first = 1'b0;
			if (fin && on_count) return;
			send_byte(8'($urandom_range(0, 255)), 1'b0, fin);
			if (fin) return;
			px += cnt;
		end
		if (open_end) begin
			// finish the same tile one pixel per byte, then one byte past its end
			set_mode($urandom_range(0, 1) ? MODE_RAW : MODE_SPARE);
			repeat (left + 1) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end
	endtask

	task automatic random_stretch();
		int n;
		logic [1:0] m;
		m = 2'($urandom_range(0, 3));
		n = $urandom_range(8, 48);
		if ($urandom_range(0, 9) < 3) begin
			fill_tile(END_ANY);
			return;
		end
		// sometimes keep the mode, sometimes switch without a new tile
		if ($urandom_range(0, 3) != 0) set_mode(m);
		for (int i = 0; i < n; i++) begin
			send_byte(8'($urandom_range(0, 255)),
				(i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 39) == 0),
				$urandom_range(0, 29) == 0);
		end
	endtask

	// the long hold starts once the sender is offering bytes again
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done && in_valid) begin
				out_ready <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		idle_run = 0;
		while (idle_run < WATCH_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("timeout: no transfer for %0d cycles", WATCH_LIMIT);
		$display("tile_run_length_decoder verification failed");
		$finish;
	end

	initial begin
		int base;
		int forced[3];
		forced = '{END_EXACT, END_OVERFLOW, END_OPEN};
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_data   <= MODE_RAW;
		in_valid   <= 1'b0;
		data_byte  <= 8'd0;
		tile_start <= 1'b0;
		data_end   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(MODE_RAW);
		send_byte(8'h55, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'hA5, 1'b0, 1'b1);
		send_byte(8'h12, 1'b0, 1'b0);
		set_mode(MODE_SPARE);
		send_byte(8'h80, 1'b1, 1'b0);
		send_byte(8'h7F, 1'b1, 1'b0);
		set_mode(MODE_BYTE);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hC3, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h72, 1'b0, 1'b0);
		send_byte(8'h5A, 1'b0, 1'b0);
		// position 369; a 15-pixel nibble run lands on a row start
		set_mode(MODE_NIBBLE);
		send_byte(8'hF3, 1'b0, 1'b0);
		send_byte(8'h9C, 1'b0, 1'b0);
		send_byte(8'h21, 1'b0, 1'b0);
		send_byte(8'h47, 1'b0, 1'b0);
		send_byte(8'hE8, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'h0B, 1'b1, 1'b0);
		send_byte(8'h6D, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);

		base = bytes_sent;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 46;
				recv_idle_pct = 38;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req = 1'b1;
			end
			fill_tile(forced[ph]);
			while (bytes_sent < base + (ph + 1) * PHASE_ITEMS) random_stretch();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d compressed bytes across raw, nibble and byte modes, %0d mode writes",
			bytes_sent, cfg_writes);
		$display("checked %0d runs: %0d tiles filled, %0d cut short, %0d overflowed",
			runs_checked, tiles_full, tiles_early, tiles_ovf);
		if (mismatch_count == 0)
			$display("tile_run_length_decoder verification clean");
		else
			$display("tile_run_length_decoder verification failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/tlrd_pkg.sv
sv/tlrd_in_reg.sv
sv/tlrd_core.sv
sv/tile_run_length_decoder.sv
test/tlrd_run_checker.sv
test/tile_run_length_decoder_test.sv
